/* rtl/sra_pkg.sv */
// Shared types, constants and the control store of the shelf rectangle allocator.
`timescale 1ns / 1ps
`default_nettype none

package sra_pkg;

    // Field widths
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int ST_W      = 3;
    localparam int CFG_IDX_W = 1;

    // Atlas size after reset
    localparam logic [DIM_W-1:0] ATLAS_RESET = 13'd1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_W = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_H = 1'b1;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_SAME    = 3'd0,
        ST_NEW     = 3'd1,
        ST_TALLER  = 3'd2,
        ST_ZERO    = 3'd3,
        ST_NOROOM  = 3'd4
    } t_status;

    // Microprogram steps
    typedef enum logic [2:0] {
        STEP_IDLE   = 3'd0,
        STEP_CHECK  = 3'd1,
        STEP_SCAN   = 3'd2,
        STEP_DECIDE = 3'd3,
        STEP_BEST   = 3'd4,
        STEP_NEW    = 3'd5,
        STEP_EMIT   = 3'd6
    } t_step;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_LATCH = 3'd1,
        OP_INIT  = 3'd2,
        OP_SCAN  = 3'd3,
        OP_NEW   = 3'd4,
        OP_BEST  = 3'd5,
        OP_EMIT  = 3'd6
    } t_op;

    // Branch conditions
    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_IN_FIRE  = 3'd2,
        C_FAIL     = 3'd3,
        C_HIT      = 3'd4,
        C_SCANNING = 3'd5,
        C_NEW_OK   = 3'd6,
        C_OUT_FREE = 3'd7
    } t_cond;

    // One control word: jump if jump_cond, else stay if hold_cond, else fall through
    typedef struct packed {
        t_op   op;
        t_cond jump_cond;
        t_step jump_to;
        t_cond hold_cond;
    } t_ctrl;

    // Status flags from the datapath back to the sequencer
    typedef struct packed {
        logic in_fire;
        logic fail;
        logic hit;
        logic scanning;
        logic new_ok;
        logic out_free;
    } t_flags;

    // Control store
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl c;
        unique case (step)
            STEP_IDLE:   c = '{op: OP_LATCH, jump_cond: C_IN_FIRE, jump_to: STEP_CHECK,
                               hold_cond: C_ALWAYS};
            STEP_CHECK:  c = '{op: OP_INIT, jump_cond: C_FAIL, jump_to: STEP_EMIT,
                               hold_cond: C_NEVER};
            STEP_SCAN:   c = '{op: OP_SCAN, jump_cond: C_HIT, jump_to: STEP_EMIT,
                               hold_cond: C_SCANNING};
            STEP_DECIDE: c = '{op: OP_NOP, jump_cond: C_NEW_OK, jump_to: STEP_NEW,
                               hold_cond: C_NEVER};
            STEP_BEST:   c = '{op: OP_BEST, jump_cond: C_ALWAYS, jump_to: STEP_EMIT,
                               hold_cond: C_NEVER};
            STEP_NEW:    c = '{op: OP_NEW, jump_cond: C_ALWAYS, jump_to: STEP_EMIT,
                               hold_cond: C_NEVER};
            STEP_EMIT:   c = '{op: OP_EMIT, jump_cond: C_OUT_FREE, jump_to: STEP_IDLE,
                               hold_cond: C_ALWAYS};
            default:     c = '{op: OP_NOP, jump_cond: C_ALWAYS, jump_to: STEP_IDLE,
                               hold_cond: C_NEVER};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/sra_req_if.sv */
// Request channel: rectangle size words.
`timescale 1ns / 1ps
`default_nettype none

interface sra_req_if;
    logic                        valid;
    logic                        ready;
    logic [sra_pkg::DIM_W-1:0]   rect_width;
    logic [sra_pkg::DIM_W-1:0]   rect_height;

    modport source (output valid, output rect_width, output rect_height, input ready);
    modport sink   (input valid, input rect_width, input rect_height, output ready);
endinterface

`default_nettype wire

/* rtl/sra_res_if.sv */
// Result channel: placement status and position words.
`timescale 1ns / 1ps
`default_nettype none

interface sra_res_if;
    logic                        valid;
    logic                        ready;
    logic [sra_pkg::ST_W-1:0]    status;
    logic [sra_pkg::POS_W-1:0]   pos_x;
    logic [sra_pkg::POS_W-1:0]   pos_y;

    modport source (output valid, output status, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input status, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

/* rtl/sra_seq.sv */
// Microprogram sequencer: step counter, control store lookup and branch logic.
`timescale 1ns / 1ps
`default_nettype none

module sra_seq (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire sra_pkg::t_flags i_flags,
    output sra_pkg::t_ctrl  o_ctrl
);

    sra_pkg::t_step r_pc;
    sra_pkg::t_step n_pc;

    function automatic logic test(input sra_pkg::t_cond c, input sra_pkg::t_flags f);
        logic t;
        unique case (c)
            sra_pkg::C_NEVER:    t = 1'b0;
            sra_pkg::C_ALWAYS:   t = 1'b1;
            sra_pkg::C_IN_FIRE:  t = f.in_fire;
            sra_pkg::C_FAIL:     t = f.fail;
            sra_pkg::C_HIT:      t = f.hit;
            sra_pkg::C_SCANNING: t = f.scanning;
            sra_pkg::C_NEW_OK:   t = f.new_ok;
            sra_pkg::C_OUT_FREE: t = f.out_free;
            default:             t = 1'b0;
        endcase
        return t;
    endfunction

    // Step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= sra_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Control word and next step
    always_comb begin
        o_ctrl = sra_pkg::ucode(r_pc);
        priority if (test(o_ctrl.jump_cond, i_flags)) begin
            n_pc = o_ctrl.jump_to;
        end else if (test(o_ctrl.hold_cond, i_flags)) begin
            n_pc = r_pc;
        end else begin
            n_pc = sra_pkg::t_step'(r_pc + 3'd1);
        end
    end

endmodule

`default_nettype wire

/* rtl/sra_shelf_mem.sv */
// Shelf store: used width and height per shelf, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sra_shelf_mem #(
    parameter int MAX_SHELVES = 256,
    localparam int AW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1
) (
    input  wire                            i_clk,
    input  wire                            i_rd_en,
    input  wire [AW-1:0]                   i_rd_addr,
    output logic [sra_pkg::DIM_W-1:0]      o_rd_used,
    output logic [sra_pkg::DIM_W-1:0]      o_rd_height,
    input  wire                            i_we_used,
    input  wire                            i_we_height,
    input  wire [AW-1:0]                   i_wr_addr,
    input  wire [sra_pkg::DIM_W-1:0]       i_wr_used,
    input  wire [sra_pkg::DIM_W-1:0]       i_wr_height
);

    logic [sra_pkg::DIM_W-1:0] r_used_mem   [MAX_SHELVES];
    logic [sra_pkg::DIM_W-1:0] r_height_mem [MAX_SHELVES];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we_used) begin
            r_used_mem[i_wr_addr] <= i_wr_used;
        end
        if (i_we_height) begin
            r_height_mem[i_wr_addr] <= i_wr_height;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_used   <= r_used_mem[i_rd_addr];
            o_rd_height <= r_height_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sra_datapath.sv */
// Datapath: atlas registers, shelf scan, best-fit tracking, result and output registers.
`timescale 1ns / 1ps
`default_nettype none

module sra_datapath #(
    parameter int MAX_SHELVES = 256,
    localparam int AW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire sra_pkg::t_ctrl            i_ctrl,
    output sra_pkg::t_flags                o_flags,
    sra_req_if.sink                        i_req,
    sra_res_if.source                      o_res,
    input  wire                            i_cfg_we,
    input  wire [sra_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [sra_pkg::DIM_W-1:0]       i_cfg_data,
    output logic                           o_rd_en,
    output logic [AW-1:0]                  o_rd_addr,
    input  wire [sra_pkg::DIM_W-1:0]       i_rd_used,
    input  wire [sra_pkg::DIM_W-1:0]       i_rd_height,
    output logic                           o_we_used,
    output logic                           o_we_height,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [sra_pkg::DIM_W-1:0]      o_wr_used,
    output logic [sra_pkg::DIM_W-1:0]      o_wr_height
);

    localparam int CW = $clog2(MAX_SHELVES + 1);
    localparam int DW = sra_pkg::DIM_W;
    localparam int PW = sra_pkg::POS_W;

    // Configuration
    logic [DW-1:0] r_aw, r_ah;
    // Request being worked on
    logic [DW-1:0] r_w, r_h, n_w, n_h;
    // Shelf count and scan state
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_live, n_live;
    logic [AW-1:0] r_ev_idx, n_ev_idx;
    logic [DW-1:0] r_yoff, n_yoff;
    // Best taller shelf so far
    logic          r_found, n_found;
    logic [AW-1:0] r_best, n_best;
    logic [DW-1:0] r_best_h, n_best_h;
    logic [DW-1:0] r_best_y, n_best_y;
    logic [DW-1:0] r_best_used, n_best_used;
    // Pending result
    sra_pkg::t_status r_res_status, n_res_status;
    logic [PW-1:0] r_res_x, n_res_x, r_res_y, n_res_y;
    // Output register
    logic          r_out_valid, n_out_valid;
    sra_pkg::t_status r_out_status, n_out_status;
    logic [PW-1:0] r_out_x, n_out_x, r_out_y, n_out_y;

    logic          issue, room, same_h, taller, better, zero_sz, too_wide, out_free;
    logic [DW:0]   sum_w, y_need;
    logic [DW-1:0] best_sum;

    // Compares shared by the steps
    always_comb begin
        issue    = r_idx < r_count;
        sum_w    = {1'b0, i_rd_used} + {1'b0, r_w};
        room     = sum_w <= {1'b0, r_aw};
        same_h   = i_rd_height == r_h;
        taller   = i_rd_height > r_h;
        better   = !r_found || (i_rd_height < r_best_h);
        zero_sz  = (r_w == '0) || (r_h == '0);
        too_wide = r_w > r_aw;
        y_need   = {1'b0, r_yoff} + {1'b0, r_h};
        best_sum = r_best_used + r_w;
        out_free = !r_out_valid || o_res.ready;
    end

    // Flags to the sequencer
    always_comb begin
        o_flags.in_fire  = (i_ctrl.op == sra_pkg::OP_LATCH) && i_req.valid;
        o_flags.fail     = zero_sz || too_wide;
        o_flags.hit      = (i_ctrl.op == sra_pkg::OP_SCAN) && r_live && room && same_h;
        o_flags.scanning = issue || r_live;
        o_flags.new_ok   = (r_count < CW'(MAX_SHELVES)) && (y_need <= {1'b0, r_ah});
        o_flags.out_free = out_free;
    end

    assign i_req.ready  = (i_ctrl.op == sra_pkg::OP_LATCH);
    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_out_status;
    assign o_res.pos_x  = r_out_x;
    assign o_res.pos_y  = r_out_y;

    // Operation decode
    always_comb begin
        n_w          = r_w;
        n_h          = r_h;
        n_count      = r_count;
        n_idx        = r_idx;
        n_live       = r_live;
        n_ev_idx     = r_ev_idx;
        n_yoff       = r_yoff;
        n_found      = r_found;
        n_best       = r_best;
        n_best_h     = r_best_h;
        n_best_y     = r_best_y;
        n_best_used  = r_best_used;
        n_res_status = r_res_status;
        n_res_x      = r_res_x;
        n_res_y      = r_res_y;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_idx[AW-1:0];
        o_we_used    = 1'b0;
        o_we_height  = 1'b0;
        o_wr_addr    = r_ev_idx;
        o_wr_used    = sum_w[DW-1:0];
        o_wr_height  = r_h;

        unique case (i_ctrl.op)
            sra_pkg::OP_NOP: begin
            end
            sra_pkg::OP_LATCH: begin
                if (i_req.valid) begin
                    n_w = i_req.rect_width;
                    n_h = i_req.rect_height;
                end
            end
            // clear scan state, preload the failure result
            sra_pkg::OP_INIT: begin
                n_idx        = '0;
                n_live       = 1'b0;
                n_yoff       = '0;
                n_found      = 1'b0;
                n_res_status = zero_sz ? sra_pkg::ST_ZERO : sra_pkg::ST_NOROOM;
                n_res_x      = '0;
                n_res_y      = '0;
            end
            // read shelf r_idx while judging the shelf read last cycle
            sra_pkg::OP_SCAN: begin
                o_rd_en  = issue;
                n_live   = issue;
                n_ev_idx = r_idx[AW-1:0];
                if (issue) begin
                    n_idx = CW'(r_idx + 1'b1);
                end
                if (r_live) begin
                    if (room && same_h) begin
                        o_we_used    = 1'b1;
                        n_res_status = sra_pkg::ST_SAME;
                        n_res_x      = i_rd_used[PW-1:0];
                        n_res_y      = r_yoff[PW-1:0];
                    end else begin
                        if (room && taller && better) begin
                            n_found     = 1'b1;
                            n_best      = r_ev_idx;
                            n_best_h    = i_rd_height;
                            n_best_y    = r_yoff;
                            n_best_used = i_rd_used;
                        end
                        n_yoff = r_yoff + i_rd_height;
                    end
                end
            end
            // open a shelf below the last one
            sra_pkg::OP_NEW: begin
                o_we_used    = 1'b1;
                o_we_height  = 1'b1;
                o_wr_addr    = r_count[AW-1:0];
                o_wr_used    = r_w;
                n_count      = CW'(r_count + 1'b1);
                n_res_status = sra_pkg::ST_NEW;
                n_res_x      = '0;
                n_res_y      = r_yoff[PW-1:0];
            end
            // fall back to the tightest taller shelf
            sra_pkg::OP_BEST: begin
                if (r_found) begin
                    o_we_used    = 1'b1;
                    o_wr_addr    = r_best;
                    o_wr_used    = best_sum;
                    n_res_status = sra_pkg::ST_TALLER;
                    n_res_x      = r_best_used[PW-1:0];
                    n_res_y      = r_best_y[PW-1:0];
                end
            end
            sra_pkg::OP_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_x      = r_res_x;
                    n_out_y      = r_res_y;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw        <= sra_pkg::ATLAS_RESET;
            r_ah        <= sra_pkg::ATLAS_RESET;
            r_count     <= '0;
            r_idx       <= '0;
            r_live      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sra_pkg::CFG_ATLAS_W: r_aw <= i_cfg_data;
                    sra_pkg::CFG_ATLAS_H: r_ah <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_live      <= n_live;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_w          <= n_w;
        r_h          <= n_h;
        r_ev_idx     <= n_ev_idx;
        r_yoff       <= n_yoff;
        r_best       <= n_best;
        r_best_h     <= n_best_h;
        r_best_y     <= n_best_y;
        r_best_used  <= n_best_used;
        r_res_status <= n_res_status;
        r_res_x      <= n_res_x;
        r_res_y      <= n_res_y;
        r_out_status <= n_out_status;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SHELVES))
        else $error("shelf count beyond capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("shelf count moved by other than one");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("scan pointer passed the shelf count");

    a_best_taller: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == sra_pkg::OP_BEST && r_found) |-> (r_best_h > r_h))
        else $error("best-fit shelf not taller than request");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_ctrl.op == sra_pkg::OP_EMIT))
        else $error("result word loaded outside the emit step");

endmodule

`default_nettype wire

/* rtl/shelf_rectangle_allocator_core.sv */
// Shelf rectangle allocator, top level.
//
// Places rectangles in an atlas split into horizontal shelves. A request word
// (rect_width, rect_height) arrives on i_req; one result word (status, pos_x,
// pos_y) leaves on o_res for every request. Both use valid/ready and move a
// word on a clock edge where both are high. Atlas width and height are set
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must set them only while
// no request is in flight, since the block does not enforce it.
// One request at a time. A zero or over-wide request skips the scan and puts
// its result word on o_res; otherwise the scan of the shelf store costs one
// read per open shelf. The next request is taken in the cycle after the
// result word is loaded. An exact-height hit ends the scan early.
//
//
// Reset (synchronous, active low) empties the atlas, sets both sizes to 1024
// and returns the sequencer to idle; the shelf store itself is not cleared.
// A stalled receiver holds the result word in the output register; the next
// request is still taken and worked on, and waits at the end for the slot.
`timescale 1ns / 1ps
`default_nettype none

module shelf_rectangle_allocator_core #(
    parameter int MAX_SHELVES = 256
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    sra_req_if.sink                        i_req,
    sra_res_if.source                      o_res,
    input  wire                            i_cfg_we,
    input  wire [sra_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [sra_pkg::DIM_W-1:0]       i_cfg_data
);

    localparam int AW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;

    sra_pkg::t_ctrl  ctrl;
    sra_pkg::t_flags flags;

    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [sra_pkg::DIM_W-1:0] rd_used, rd_height;
    logic                      we_used, we_height;
    logic [AW-1:0]             wr_addr;
    logic [sra_pkg::DIM_W-1:0] wr_used, wr_height;

    sra_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    sra_shelf_mem #(
        .MAX_SHELVES (MAX_SHELVES)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_rd_used   (rd_used),
        .o_rd_height (rd_height),
        .i_we_used   (we_used),
        .i_we_height (we_height),
        .i_wr_addr   (wr_addr),
        .i_wr_used   (wr_used),
        .i_wr_height (wr_height)
    );

    sra_datapath #(
        .MAX_SHELVES (MAX_SHELVES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_flags     (flags),
        .i_req       (i_req),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_used   (rd_used),
        .i_rd_height (rd_height),
        .o_we_used   (we_used),
        .o_we_height (we_height),
        .o_wr_addr   (wr_addr),
        .o_wr_used   (wr_used),
        .o_wr_height (wr_height)
    );

endmodule

`default_nettype wire
